/* sv/asc_pkg.sv */
package asc_pkg;

    localparam int LOGIT_W         = 16;
    localparam int LABEL_W         = 10;
    localparam int CONF_W          = 16;
    localparam int SUM_W           = 32;
    localparam int MAG_W           = 16;
    localparam int EXP_T_W         = 17;
    localparam int POW2_W          = 17;
    localparam int MAX_CLASSES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [EXP_T_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam logic [SUM_W-1:0]   ONE_Q16   = 32'h0001_0000;
    localparam logic [CONF_W-1:0]  CONF_MAX  = 16'hFFFF;

    // How the back end must fold one logit into the running sum.
    typedef enum logic [1:0] {
        KIND_FIRST = 2'd0,  // opens the vector: sum becomes 1.0
        KIND_RAISE = 2'd1,  // new maximum: rescale sum, add 1.0
        KIND_ADD   = 2'd2,  // not above maximum: add exp(-mag)
        KIND_SKIP  = 2'd3   // past the class limit: sum unchanged
    } asc_kind_t;

    typedef struct packed {
        asc_kind_t          kind;
        logic [MAG_W-1:0]   mag;
        logic               last;
        logic [LABEL_W-1:0] label;
        logic               too_many;
    } asc_entry_t;

    // round(65536 * 2^(-j/16))
    function automatic logic [POW2_W-1:0] pow2_frac(input logic [3:0] j);
        logic [POW2_W-1:0] r;
        case (j)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd62757;
            4'd2:    r = 17'd60097;
            4'd3:    r = 17'd57549;
            4'd4:    r = 17'd55109;
            4'd5:    r = 17'd52773;
            4'd6:    r = 17'd50535;
            4'd7:    r = 17'd48393;
            4'd8:    r = 17'd46341;
            4'd9:    r = 17'd44376;
            4'd10:   r = 17'd42495;
            4'd11:   r = 17'd40693;
            4'd12:   r = 17'd38968;
            4'd13:   r = 17'd37316;
            4'd14:   r = 17'd35734;
            4'd15:   r = 17'd34219;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

/* sv/asc_front.sv */
module asc_front
    import asc_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LOGIT_W-1:0] logit,
    input  logic               last_logit,
    input  logic               logit_valid,
    output logic               logit_ready,
    output asc_entry_t         push_entry,
    output logic               push_valid,
    input  logic               push_ready
);

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);

    logic [LOGIT_W-1:0] max_reg,   max_next;
    logic [LABEL_W-1:0] best_reg,  best_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg,   ovf_next;

    logic               accept;
    logic               full;
    logic               above;
    logic [LOGIT_W:0]   up_diff;
    logic [LOGIT_W:0]   down_diff;

    assign logit_ready = push_ready;
    assign push_valid  = logit_valid;
    assign accept      = logit_valid & push_ready;

    assign full      = (count_reg >= CNT_W'(MAX_CLASSES));
    assign above     = ($signed(logit) > $signed(max_reg));
    assign up_diff   = {logit[LOGIT_W-1], logit} - {max_reg[LOGIT_W-1], max_reg};
    assign down_diff = {max_reg[LOGIT_W-1], max_reg} - {logit[LOGIT_W-1], logit};

    // Classify the logit against the running max and tag it with the label so far.
    always_comb
    begin
        max_next   = max_reg;
        best_next  = best_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        push_entry.kind = KIND_SKIP;
        push_entry.mag  = '0;
        if (full)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0)
            begin
                push_entry.kind = KIND_FIRST;
                max_next        = logit;
                best_next       = '0;
            end
            else if (above)
            begin
                push_entry.kind = KIND_RAISE;
                push_entry.mag  = up_diff[MAG_W-1:0];
                max_next        = logit;
                best_next       = LABEL_W'(count_reg);
            end
            else
            begin
                push_entry.kind = KIND_ADD;
                push_entry.mag  = down_diff[MAG_W-1:0];
            end
        end
        push_entry.last     = last_logit;
        push_entry.label    = best_next;
        push_entry.too_many = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            best_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_logit)
            begin
                max_reg   <= '0;
                best_reg  <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                max_reg   <= max_next;
                best_reg  <= best_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

/* sv/asc_queue.sv */
module asc_queue
    import asc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  asc_entry_t push_entry,
    input  logic       push_valid,
    output logic       push_ready,
    output asc_entry_t pop_entry,
    output logic       pop_valid,
    input  logic       pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    asc_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/asc_back.sv */
module asc_back
    import asc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  asc_entry_t         pop_entry,
    input  logic               pop_valid,
    output logic               pop_ready,
    output logic [LABEL_W-1:0] class_label,
    output logic [CONF_W-1:0]  confidence,
    output logic               too_many,
    output logic               result_valid,
    input  logic               result_ready
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_PUT  = 6'b100000
    } asc_state_t;

    asc_state_t         state_reg, state_next;
    asc_kind_t          kind_reg,  kind_next;
    logic               last_reg,  last_next;
    logic [LABEL_W-1:0] label_reg, label_next;
    logic               tm_reg,    tm_next;
    logic [EXP_T_W-1:0] t_reg,     t_next;
    logic [SUM_W-1:0]   p_reg,     p_next;
    logic [8:0]         k_reg,     k_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [SUM_W-1:0]   rem_reg,   rem_next;
    logic [CONF_W-1:0]  quo_reg,   quo_next;
    logic [3:0]         bit_reg,   bit_next;

    logic [LABEL_W-1:0] class_label_reg, class_label_next;
    logic [CONF_W-1:0]  confidence_reg,  confidence_next;
    logic               too_many_reg,    too_many_next;
    logic               out_valid_reg,   out_valid_next;

    logic [MAG_W+EXP_T_W-1:0]  t_prod;
    logic [SUM_W+POW2_W-1:0]   p_prod;
    logic [SUM_W-1:0]          scale_src;
    logic [SUM_W-1:0]          scaled;
    logic [SUM_W-1:0]          add_a, add_b;
    logic [SUM_W:0]            add_sum;
    logic [SUM_W:0]            rem_shift;
    logic [SUM_W:0]            rem_diff;

    assign pop_ready    = (state_reg == ST_IDLE);
    assign class_label  = class_label_reg;
    assign confidence   = confidence_reg;
    assign too_many     = too_many_reg;
    assign result_valid = out_valid_reg;

    assign t_prod    = pop_entry.mag * LOG2E_Q16;
    assign scale_src = (kind_reg == KIND_RAISE) ? sum_reg : ONE_Q16;
    assign p_prod    = scale_src * pow2_frac(t_reg[7:4]);
    assign scaled    = (k_reg >= 9'd32) ? '0 : (p_reg >> k_reg[4:0]);
    assign add_a     = (kind_reg == KIND_RAISE) ? scaled : sum_reg;
    assign add_b     = (kind_reg == KIND_RAISE) ? ONE_Q16 : scaled;
    assign add_sum   = {1'b0, add_a} + {1'b0, add_b};
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, sum_reg};

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        last_next        = last_reg;
        label_next       = label_reg;
        tm_next          = tm_reg;
        t_next           = t_reg;
        p_next           = p_reg;
        k_next           = k_reg;
        sum_next         = sum_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        bit_next         = bit_reg;
        class_label_next = class_label_reg;
        confidence_next  = confidence_reg;
        too_many_next    = too_many_reg;
        out_valid_next   = out_valid_reg & ~result_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    kind_next  = pop_entry.kind;
                    last_next  = pop_entry.last;
                    label_next = pop_entry.label;
                    tm_next    = pop_entry.too_many;
                    t_next     = t_prod[MAG_W+EXP_T_W-1:MAG_W];
                    case (pop_entry.kind)
                        KIND_FIRST:
                        begin
                            sum_next   = ONE_Q16;
                            state_next = pop_entry.last ? ST_PREP : ST_IDLE;
                        end
                        KIND_SKIP:
                        begin
                            state_next = pop_entry.last ? ST_PREP : ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                // The product stays below 2^48, so its top bit is always clear.
                p_next     = p_prod[SUM_W+15:16];
                k_next     = t_reg[EXP_T_W-1:8];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sum_next   = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
                state_next = last_reg ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                // A sum at or below 1.0 gives a quotient of at least 1.0: saturate.
                if (sum_reg <= ONE_Q16)
                begin
                    quo_next   = CONF_MAX;
                    state_next = ST_PUT;
                end
                else
                begin
                    rem_next   = ONE_Q16;
                    quo_next   = '0;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!rem_diff[SUM_W])
                begin
                    rem_next = rem_diff[SUM_W-1:0];
                    quo_next = {quo_reg[CONF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[SUM_W-1:0];
                    quo_next = {quo_reg[CONF_W-2:0], 1'b0};
                end
                bit_next = bit_reg + 4'd1;
                if (bit_reg == 4'd15)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    class_label_next = label_reg;
                    confidence_next  = quo_reg;
                    too_many_next    = tm_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        last_reg        <= last_next;
        label_reg       <= label_next;
        tm_reg          <= tm_next;
        t_reg           <= t_next;
        p_reg           <= p_next;
        k_reg           <= k_next;
        sum_reg         <= sum_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        bit_reg         <= bit_next;
        class_label_reg <= class_label_next;
        confidence_reg  <= confidence_next;
        too_many_reg    <= too_many_next;
    end

endmodule

/* sv/argmax_softmax_confidence.sv */
// Streaming argmax with softmax top-1 confidence. Feed one signed Q8.8 logit
// per transaction and mark the final one of the vector with last_logit; one
// result transaction follows per vector, carrying the index of the first
// strictly largest logit, its softmax probability as unsigned Q0.16
// (saturating at 65535) and a flag set when the vector held more than
// MAX_CLASSES logits, whose extra logits are ignored. The front end takes a
// logit every cycle while its QUEUE_DEPTH-entry queue has room and tracks
// the maximum and label itself; the back end folds each logit into the
// exponential sum with two multiplies, one logit at a time: the first or an
// over-limit logit is folded in ST_IDLE, any other passes through ST_MUL and
// ST_ACC before the next is taken. Closing a vector adds ST_PREP to test for
// saturation, then a bit-serial divider for the 16-bit quotient (skipped
// when the confidence saturates) and ST_PUT to load the result register,
// which waits there for the result register to drain.
module argmax_softmax_confidence
    import asc_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LOGIT_W-1:0] logit,
    input  logic               last_logit,
    input  logic               logit_valid,
    output logic               logit_ready,
    output logic [LABEL_W-1:0] class_label,
    output logic [CONF_W-1:0]  confidence,
    output logic               too_many,
    output logic               result_valid,
    input  logic               result_ready
);

    asc_entry_t push_entry;
    logic       push_valid;
    logic       push_ready;
    asc_entry_t pop_entry;
    logic       pop_valid;
    logic       pop_ready;

    // Classify each logit and track max, label and class count.
    asc_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .logit       (logit),
        .last_logit  (last_logit),
        .logit_valid (logit_valid),
        .logit_ready (logit_ready),
        .push_entry  (push_entry),
        .push_valid  (push_valid),
        .push_ready  (push_ready)
    );

    // Decouple the front, which takes a logit whenever there is room, from the back end.
    asc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Accumulate the relative exponential sum, divide, and hold the result.
    asc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_entry    (pop_entry),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .class_label  (class_label),
        .confidence   (confidence),
        .too_many     (too_many),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
